// ===== rtl/lpfm_pkg.sv =====
// Package for the LRU pinned frame manager: status and command codes, shared types.
// No dependencies.
`timescale 1ns / 1ps
package lpfm_pkg;
   localparam int DefNumFrames = 16;
   localparam int PageIdBits = 16;
   localparam int CfgBits = 5;
   localparam logic [CfgBits-1:0] CfgReset = 5'd16;

   localparam logic [2:0] ST_HIT = 3'd0;
   localparam logic [2:0] ST_LOADED_FREE = 3'd1;
   localparam logic [2:0] ST_LOADED_EVICT = 3'd2;
   localparam logic [2:0] ST_NO_FRAME = 3'd3;
   localparam logic [2:0] ST_UNPINNED = 3'd4;
   localparam logic [2:0] ST_ALREADY_FREE = 3'd5;
   localparam logic [2:0] ST_NOT_RESIDENT = 3'd6;

   localparam logic CMD_PIN = 1'b0;
   localparam logic CMD_UNPIN = 1'b1;

   // Commands from the controller to the datapath.
   typedef struct packed {
      logic load;    // capture request, start scan
      logic scan;    // step the scan over one frame
      logic commit;  // apply update and form result
   } lpfm_cmd_type;

   // Status from the datapath to the controller.
   typedef struct packed {
      logic scan_done;
   } lpfm_stat_type;
endpackage

// ===== rtl/lpfm_if.sv =====
// Valid/ready channel interface carrying a generic payload.
// Depends on nothing.
`timescale 1ns / 1ps
interface lpfm_if #(parameter type payload_type = logic) ();
   logic        valid;
   logic        ready;
   payload_type data;
   modport source (output valid, output data, input ready);
   modport sink (input valid, input data, output ready);
endinterface

// ===== rtl/lpfm_ctrl.sv =====
// Controller for the frame manager: sequences load, scan and commit.
// Depends on lpfm_pkg.
`timescale 1ns / 1ps
module lpfm_ctrl
   import lpfm_pkg::*;
(
   input  logic          clock,
   input  logic          reset,
   input  logic          req_valid,
   output logic          req_ready,
   output logic          rsp_valid,
   input  logic          rsp_ready,
   output lpfm_cmd_type  cmd,
   input  lpfm_stat_type stat
);
   typedef enum logic [2:0] {
      S_IDLE = 3'b001,
      S_SCAN = 3'b010,
      S_DONE = 3'b100
   } state_type;

   state_type state_ff, state_in;
   logic      out_valid_ff, out_valid_in;

   // The next request can be taken while the previous result still waits.
   assign req_ready = (state_ff == S_IDLE);
   assign rsp_valid = out_valid_ff;

   always_comb begin
      state_in     = state_ff;
      out_valid_in = out_valid_ff && !rsp_ready;
      cmd          = '0;
      unique case (state_ff)
         S_IDLE: begin
            if (req_valid) begin
               cmd.load = 1'b1;
               state_in = S_SCAN;
            end
         end
         S_SCAN: begin
            cmd.scan = 1'b1;
            if (stat.scan_done) state_in = S_DONE;
         end
         S_DONE: begin
            if (!out_valid_ff || rsp_ready) begin
               cmd.commit   = 1'b1;
               out_valid_in = 1'b1;
               state_in     = S_IDLE;
            end
         end
         default: state_in = S_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= S_IDLE;
         out_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         out_valid_ff <= out_valid_in;
      end
   end

`ifndef SYNTH
   a_commit_in_done: assert property (@(posedge clock) disable iff (reset)
      cmd.commit |-> state_ff == S_DONE) else $error("commit outside done");
   a_commit_valid: assert property (@(posedge clock) disable iff (reset)
      cmd.commit |=> rsp_valid) else $error("commit without result");
   a_load_idle: assert property (@(posedge clock) disable iff (reset)
      cmd.load |=> !req_ready) else $error("accepted while busy");
`endif
endmodule

// ===== rtl/lpfm_dp.sv =====
// Datapath for the frame manager: frame table, serial scan, update and result register.
// Depends on lpfm_pkg.
`timescale 1ns / 1ps
module lpfm_dp
   import lpfm_pkg::*;
#(
   parameter int NUM_FRAMES   = DefNumFrames
) (
   input  logic                  clock,
   input  logic                  reset,
   input  logic [CfgBits-1:0]    limit_cfg,
   input  logic                  in_command,
   input  logic [PageIdBits-1:0] in_page_id,
   input  logic                  in_mark_dirty,
   input  lpfm_cmd_type          cmd,
   output lpfm_stat_type         stat,
   output logic [2:0]            out_status,
   output logic [3:0]            out_frame_index,
   output logic [7:0]            out_pin_count_after,
   output logic                  out_dirty_after,
   output logic [PageIdBits-1:0] out_evicted_page,
   output logic                  out_writeback,
   output logic                  out_count_saturated
);
   localparam int FW = $clog2(NUM_FRAMES);
   localparam int CW = FW + 1;

   logic                  valid_ff [NUM_FRAMES];
   logic [PageIdBits-1:0] page_ff  [NUM_FRAMES];
   logic [7:0]            pins_ff  [NUM_FRAMES];
   logic                  dirty_ff [NUM_FRAMES];
   logic [FW-1:0]         rank_ff  [NUM_FRAMES];

   logic                  cmd_ff;
   logic [PageIdBits-1:0] pid_ff;
   logic                  mark_ff;
   logic [CW-1:0]         idx_ff;
   logic                  hit_ff, free_ff, vic_ff;
   logic [FW-1:0]         hit_idx_ff, free_idx_ff, vic_idx_ff, vic_rank_ff;
   logic [CW-1:0]         limit_ff;

   logic [FW-1:0] cur;
   logic          cur_in_limit;
   assign cur = idx_ff[FW-1:0];
   assign cur_in_limit = idx_ff < limit_ff;
   assign stat.scan_done = (idx_ff == CW'(NUM_FRAMES - 1));

   // One frame per cycle: match, first free, least recent unpinned.
   always_ff @(posedge clock) begin
      if (cmd.load) begin
         cmd_ff  <= in_command;
         pid_ff  <= in_page_id;
         mark_ff <= in_mark_dirty;
         idx_ff  <= '0;
         hit_ff  <= 1'b0;
         free_ff <= 1'b0;
         vic_ff  <= 1'b0;
         limit_ff <= (32'(limit_cfg) > NUM_FRAMES) ? CW'(NUM_FRAMES) : CW'(limit_cfg);
      end else if (cmd.scan) begin
         if (!hit_ff && valid_ff[cur] && page_ff[cur] == pid_ff) begin
            hit_ff <= 1'b1;
            hit_idx_ff <= cur;
         end
         if (cur_in_limit && !free_ff && !valid_ff[cur]) begin
            free_ff <= 1'b1;
            free_idx_ff <= cur;
         end
         if (cur_in_limit && valid_ff[cur] && pins_ff[cur] == 8'd0 &&
             (!vic_ff || rank_ff[cur] > vic_rank_ff)) begin
            vic_ff <= 1'b1;
            vic_idx_ff <= cur;
            vic_rank_ff <= rank_ff[cur];
         end
         if (!stat.scan_done) idx_ff <= idx_ff + 1'b1;
      end
   end

   // Commit decision.
   logic          touch;
   logic [FW-1:0] tgt;
   logic          load_new;
   always_comb begin
      touch = 1'b0;
      load_new = 1'b0;
      tgt = hit_idx_ff;
      if (cmd_ff == CMD_PIN) begin
         if (hit_ff) begin
            touch = 1'b1;
         end else if (free_ff) begin
            touch = 1'b1; load_new = 1'b1; tgt = free_idx_ff;
         end else if (vic_ff) begin
            touch = 1'b1; load_new = 1'b1; tgt = vic_idx_ff;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         for (int i = 0; i < NUM_FRAMES; i++) valid_ff[i] <= 1'b0;
      end else if (cmd.commit) begin
         if (touch) begin
            for (int i = 0; i < NUM_FRAMES; i++) begin
               if (FW'(i) != tgt && valid_ff[i] &&
                   (!valid_ff[tgt] || rank_ff[i] < rank_ff[tgt]))
                  rank_ff[i] <= rank_ff[i] + 1'b1;
            end
            rank_ff[tgt] <= '0;
         end
         if (load_new) begin
            valid_ff[tgt] <= 1'b1;
            page_ff[tgt]  <= pid_ff;
            pins_ff[tgt]  <= 8'd1;
            dirty_ff[tgt] <= 1'b0;
         end else if (cmd_ff == CMD_PIN && hit_ff) begin
            if (pins_ff[tgt] != 8'hFF) pins_ff[tgt] <= pins_ff[tgt] + 1'b1;
         end else if (cmd_ff == CMD_UNPIN && hit_ff) begin
            if (pins_ff[tgt] != 8'd0) pins_ff[tgt] <= pins_ff[tgt] - 1'b1;
            dirty_ff[tgt] <= mark_ff;
         end
      end
   end

   // Result register.
   always_ff @(posedge clock) begin
      if (cmd.commit) begin
         out_status <= ST_NO_FRAME;
         out_frame_index <= 4'(tgt);
         out_pin_count_after <= 8'd0;
         out_dirty_after <= 1'b0;
         out_evicted_page <= '0;
         out_writeback <= 1'b0;
         out_count_saturated <= 1'b0;
         if (cmd_ff == CMD_UNPIN) begin
            if (!hit_ff) begin
               out_status <= ST_NOT_RESIDENT;
               out_frame_index <= 4'd0;
            end else begin
               out_status <= (pins_ff[tgt] != 8'd0) ? ST_UNPINNED : ST_ALREADY_FREE;
               out_pin_count_after <= (pins_ff[tgt] != 8'd0) ?
                                      pins_ff[tgt] - 1'b1 : 8'd0;
               out_dirty_after <= mark_ff;
            end
         end else if (hit_ff) begin
            out_status <= ST_HIT;
            out_pin_count_after <= (pins_ff[tgt] == 8'hFF) ? 8'hFF : pins_ff[tgt] + 1'b1;
            out_count_saturated <= (pins_ff[tgt] == 8'hFF);
            out_dirty_after <= dirty_ff[tgt];
         end else if (load_new) begin
            out_status <= free_ff ? ST_LOADED_FREE : ST_LOADED_EVICT;
            out_pin_count_after <= 8'd1;
            if (!free_ff) begin
               out_evicted_page <= page_ff[tgt];
               out_writeback <= dirty_ff[tgt];
            end
         end else begin
            out_frame_index <= 4'd0;
         end
      end
   end

`ifndef SYNTH
   a_load_valid: assert property (@(posedge clock) disable iff (reset)
      cmd.commit && load_new |=> valid_ff[$past(tgt)]) else $error("load lost");
   a_touch_rank: assert property (@(posedge clock) disable iff (reset)
      cmd.commit && touch |=> rank_ff[$past(tgt)] == '0) else $error("rank not reset");
   a_one_cmd: assert property (@(posedge clock) disable iff (reset)
      $onehot0({cmd.load, cmd.scan, cmd.commit})) else $error("commands overlap");
`endif
endmodule

// ===== rtl/lru_pinned_frame_manager.sv =====
// Top level of the LRU pinned frame manager; joins controller and datapath.
// Depends on lpfm_pkg, lpfm_if, lpfm_ctrl and lpfm_dp.
`timescale 1ns / 1ps
// Buffer pool frame table with pin counts, dirty marks and exact LRU ranks. Each
// request transfer (pin or unpin of a page id) yields one response transfer.
// A request is first captured; then a single compare unit scans the table frame
// by frame for a match, the lowest free frame and the least recent unpinned
// frame, and, once any earlier response has been taken, the update is committed
// into the response register. The next request is taken while a response
// waits. csr_we/csr_wdata set frames_in_use (reset 16); write it only when idle.
module lru_pinned_frame_manager
   import lpfm_pkg::*;
#(
   parameter int NUM_FRAMES   = DefNumFrames
) (
   input  logic clock,
   input  logic reset,
   lpfm_if.sink   req,
   lpfm_if.source rsp,
   input  logic                csr_we,
   input  logic [CfgBits-1:0]  csr_wdata
);
   logic [CfgBits-1:0] cfg_ff;
   lpfm_cmd_type  cmd;
   lpfm_stat_type stat;

   always_ff @(posedge clock) begin
      if (reset) cfg_ff <= CfgReset;
      else if (csr_we) cfg_ff <= csr_wdata;
   end

   lpfm_ctrl u_ctrl (
      .clock(clock), .reset(reset),
      .req_valid(req.valid), .req_ready(req.ready),
      .rsp_valid(rsp.valid), .rsp_ready(rsp.ready),
      .cmd(cmd), .stat(stat)
   );

   lpfm_dp #(.NUM_FRAMES(NUM_FRAMES)) u_dp (
      .clock(clock), .reset(reset), .limit_cfg(cfg_ff),
      .in_command(req.data.command), .in_page_id(req.data.page_id),
      .in_mark_dirty(req.data.mark_dirty),
      .cmd(cmd), .stat(stat),
      .out_status(rsp.data.status), .out_frame_index(rsp.data.frame_index),
      .out_pin_count_after(rsp.data.pin_count_after),
      .out_dirty_after(rsp.data.dirty_after),
      .out_evicted_page(rsp.data.evicted_page),
      .out_writeback(rsp.data.writeback),
      .out_count_saturated(rsp.data.count_saturated)
   );
endmodule
